@@ hw/rtl/tcw_pkg.sv @@
// Shared types, constants and command codes for the text console writer.
// Used by tcw_front, tcw_back and text_console_writer_unit; depends on nothing.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int POS_W      = 11;
  localparam int IDX_W      = 11;

  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int COPY_LAST     = CELL_COUNT - COLUMNS - 1;

  localparam logic [15:0] ATTR_WHITE   = 16'h0700;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_PUT     = 2'd1;
  localparam logic [1:0] OP_NEWLINE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  typedef struct packed {
    logic             action;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_pos;
    logic [15:0]      cell_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        code;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic cmd_pop;
    logic init_done;
  } back_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_front.sv @@
// Front end of the console writer: takes words, decodes them into commands
// and holds them in a two-entry queue. Depends on tcw_pkg.
`default_nettype none

module tcw_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire tcw_pkg::in_item_t  item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  output logic                    cmd_valid,
  output tcw_pkg::cmd_t           cmd,
  input  wire tcw_pkg::back_ctrl_t ctrl
);

  logic                    enable;
  tcw_pkg::cmd_t           new_cmd;
  tcw_pkg::cmd_t           entries [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr;
  logic [tcw_pkg::QPTR_W:0]   count;
  logic                    push;
  logic                    in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  assign in_range = {{(32-tcw_pkg::IDX_W){1'b0}}, item.cell_index} < 32'(tcw_pkg::CELL_COUNT);

  // Out-of-range reads and puts while disabled become no-ops that only report.
  always_comb begin
    new_cmd.code = item.char_code;
    new_cmd.addr = tcw_pkg::ADDR_W'(item.cell_index);
    if (item.action == tcw_pkg::ACT_READ) begin
      new_cmd.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
    end else if (!enable) begin
      new_cmd.op = tcw_pkg::OP_NOP;
    end else if (item.char_code == tcw_pkg::NEWLINE_CODE) begin
      new_cmd.op = tcw_pkg::OP_NEWLINE;
    end else begin
      new_cmd.op = tcw_pkg::OP_PUT;
    end
  end

  assign busy      = !ctrl.init_done || (count == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctrl.cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !ctrl.cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && ctrl.cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_back.sv @@
// Back end of the console writer: screen memory, cursor, scroll engine and
// result register. Depends on tcw_pkg.
`default_nettype none

module tcw_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire tcw_pkg::cmd_t   cmd,
  output tcw_pkg::back_ctrl_t  ctrl,
  output logic                 done,
  output tcw_pkg::out_item_t   result
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_BLANK = 3'd5;
  localparam logic [2:0] ST_REPLY = 3'd6;

  logic [15:0] screen [tcw_pkg::CELL_COUNT];
  logic [15:0] rd_data;

  logic [2:0]                  state;
  logic [tcw_pkg::ADDR_W-1:0]  sweep;
  logic [tcw_pkg::ADDR_W-1:0]  pend_addr;
  logic                        copy_pend;
  logic [tcw_pkg::COL_W-1:0]   col;
  logic [tcw_pkg::ADDR_W-1:0]  row_base;
  logic [15:0]                 value;

  logic [tcw_pkg::ADDR_W-1:0]  cursor_addr;
  logic                        mem_we;
  logic [tcw_pkg::ADDR_W-1:0]  mem_waddr;
  logic [tcw_pkg::ADDR_W-1:0]  mem_raddr;
  logic [15:0]                 mem_wdata;
  logic                        cmd_pop;
  logic                        at_last_col;
  logic                        at_last_row;

  assign cursor_addr = row_base + tcw_pkg::ADDR_W'(col);
  assign cmd_pop     = (state == ST_IDLE) && cmd_valid;
  assign at_last_col = (col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign at_last_row = (row_base == tcw_pkg::ADDR_W'(tcw_pkg::LAST_ROW_BASE));

  assign ctrl.cmd_pop   = cmd_pop;
  assign ctrl.init_done = (state != ST_CLEAR);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = tcw_pkg::BLANK_CELL;
    mem_raddr = cmd.addr;
    unique case (state)
      ST_CLEAR, ST_BLANK: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = cmd_pop && (cmd.op == tcw_pkg::OP_PUT);
        mem_waddr = cursor_addr;
        mem_wdata = tcw_pkg::ATTR_WHITE | {8'h00, cmd.code};
      end
      ST_COPY: begin
        // Reads run one cell ahead of the writes they feed.
        mem_raddr = sweep + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        mem_we    = copy_pend;
        mem_waddr = pend_addr;
        mem_wdata = rd_data;
      end
      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = pend_addr;
        mem_wdata = rd_data;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    rd_data <= screen[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      copy_pend <= 1'b0;
      col       <= '0;
      row_base  <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            value <= 16'h0000;
            if (cmd.op == tcw_pkg::OP_READ) begin
              state <= ST_READ;
            end else if (cmd.op == tcw_pkg::OP_NOP ||
                         (cmd.op == tcw_pkg::OP_PUT && !at_last_col)) begin
              if (cmd.op == tcw_pkg::OP_PUT) begin
                col <= col + 1'b1;
              end
              state <= ST_REPLY;
            end else begin
              col <= '0;
              if (at_last_row) begin
                sweep     <= '0;
                copy_pend <= 1'b0;
                state     <= ST_COPY;
              end else begin
                row_base <= row_base + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                state    <= ST_REPLY;
              end
            end
          end
        end
        ST_READ: begin
          value <= rd_data;
          state <= ST_REPLY;
        end
        ST_COPY: begin
          copy_pend <= 1'b1;
          pend_addr <= sweep;
          sweep     <= sweep + 1'b1;
          if (sweep == tcw_pkg::ADDR_W'(tcw_pkg::COPY_LAST)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          copy_pend <= 1'b0;
          sweep     <= tcw_pkg::ADDR_W'(tcw_pkg::LAST_ROW_BASE);
          state     <= ST_BLANK;
        end
        ST_BLANK: begin
          sweep <= sweep + 1'b1;
          if (sweep == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
            state <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          done              <= 1'b1;
          result.cursor_pos <= tcw_pkg::POS_W'(cursor_addr);
          result.cell_value <= value;
          state             <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only ever follows the reply state.
  a_done_after_reply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_REPLY)
    else $error("result strobe without a reply");

  // The cursor always stays on the screen.
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    32'(col) < 32'(tcw_pkg::COLUMNS) && 32'(row_base) <= 32'(tcw_pkg::LAST_ROW_BASE))
    else $error("cursor left the screen");

  // Blanking after a scroll starts at the first cell of the bottom row.
  a_blank_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLANK && $past(state) == ST_DRAIN) |->
      sweep == tcw_pkg::ADDR_W'(tcw_pkg::LAST_ROW_BASE))
    else $error("bottom row blanking misaligned");

endmodule

`default_nettype wire

@@ hw/rtl/text_console_writer_unit.sv @@
// Every accepted start ends in a done strobe with a result. When a newline or wrap
// scrolls the screen, each cell is copied up one row, one cell copied per cycle through
// the single-write-port screen memory, then the bottom row is blanked. Done cannot
// stall; the two-entry queue takes new words while the back end works, until it is full.
// After reset busy stays high while the screen memory is set to blanks; the enable
// register resets to 1 and the cursor to the top-left cell.
`default_nettype none

module text_console_writer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire tcw_pkg::in_item_t  item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  output logic                    done,
  output tcw_pkg::out_item_t      result
);

  logic                cmd_valid;
  tcw_pkg::cmd_t       cmd;
  tcw_pkg::back_ctrl_t ctrl;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctrl      (ctrl)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ tb/text_console_writer_unit_test.sv @@
// Self-checking testbench for text_console_writer_unit: drives put and read words,
// predicts the screen and cursor in a scoreboard class and compares every result.
// Depends on tcw_pkg and text_console_writer_unit only.
module text_console_writer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  class console_scoreboard;
    bit [15:0]          screen [tcw_pkg::CELL_COUNT];
    int unsigned        col;
    int unsigned        row;
    bit                 enable;
    tcw_pkg::out_item_t pending [$];
    int                 error_count;

    function new();
      foreach (screen[i]) screen[i] = tcw_pkg::BLANK_CELL;
      col = 0;
      row = 0;
      enable = 1'b1;
      error_count = 0;
    endfunction

    task report(string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function void next_line();
      col = 0;
      row++;
      if (row >= tcw_pkg::ROWS) begin
        // Scroll: every row moves up by one and the bottom row goes blank.
        for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
          screen[i] = screen[i + tcw_pkg::COLUMNS];
        for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
          screen[i] = tcw_pkg::BLANK_CELL;
        row = tcw_pkg::ROWS - 1;
      end
    endfunction

    function void note_item(tcw_pkg::in_item_t it);
      tcw_pkg::out_item_t want;
      want = '0;
      if (it.action == tcw_pkg::ACT_PUT) begin
        if (enable) begin
          if (it.char_code == tcw_pkg::NEWLINE_CODE) begin
            next_line();
          end else begin
            screen[row * tcw_pkg::COLUMNS + col] = tcw_pkg::ATTR_WHITE | {8'h00, it.char_code};
            col++;
            if (col >= tcw_pkg::COLUMNS) next_line();
          end
        end
      end else if (it.cell_index < tcw_pkg::CELL_COUNT) begin
        want.cell_value = screen[it.cell_index];
      end
      want.cursor_pos = tcw_pkg::POS_W'(row * tcw_pkg::COLUMNS + col);
      pending.push_back(want);
    endfunction

    task check_result(tcw_pkg::out_item_t got);
      tcw_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: pos %0d cell %h",
                         got.cursor_pos, got.cell_value));
        return;
      end
      want = pending.pop_front();
      if (got.cursor_pos !== want.cursor_pos)
        report($sformatf("cursor_pos %0d, predicted %0d", got.cursor_pos, want.cursor_pos));
      if (got.cell_value !== want.cell_value)
        report($sformatf("cell_value %h, predicted %h", got.cell_value, want.cell_value));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  tcw_pkg::in_item_t  item = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               done;
  tcw_pkg::out_item_t result;

  console_scoreboard sb = new();
  bit burst_mode = 1'b0;

  text_console_writer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic tcw_pkg::in_item_t put_of(logic [7:0] code);
    tcw_pkg::in_item_t it;
    it.action = tcw_pkg::ACT_PUT;
    it.char_code = code;
    it.cell_index = tcw_pkg::IDX_W'($urandom_range(0, 2047));
    return it;
  endfunction

  function automatic tcw_pkg::in_item_t read_of(int unsigned idx);
    tcw_pkg::in_item_t it;
    it.action = tcw_pkg::ACT_READ;
    it.char_code = 8'($urandom_range(0, 255));
    it.cell_index = tcw_pkg::IDX_W'(idx);
    return it;
  endfunction

  // Start stays high across back-to-back words; it drops for a gap and when the bench quiesces.
  task automatic send(tcw_pkg::in_item_t it, int gap);
    repeat (gap) @(negedge clk) start = 1'b0;
    @(negedge clk);
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(it);
  endtask

  task automatic quiesce();
    @(negedge clk) start = 1'b0;
    forever begin
      @(posedge clk);
      if (sb.pending.size() == 0) break;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.enable = value;
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic run_random(int count, int newline_pct, int read_pct);
    int unsigned here;
    int unsigned pick;
    int unsigned idx;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < read_pct) begin
        // Half the reads look just behind the cursor, where text has landed.
        here = sb.row * tcw_pkg::COLUMNS + sb.col;
        pick = $urandom_range(0, 9);
        if (pick < 5)
          idx = (here + tcw_pkg::CELL_COUNT - $urandom_range(0, 160)) % tcw_pkg::CELL_COUNT;
        else if (pick < 9) idx = $urandom_range(0, tcw_pkg::CELL_COUNT - 1);
        else idx = $urandom_range(tcw_pkg::CELL_COUNT, 2047);
        send(read_of(idx), draw_gap());
      end else if ($urandom_range(0, 99) < newline_pct) begin
        send(put_of(tcw_pkg::NEWLINE_CODE), draw_gap());
      end else begin
        send(put_of(8'($urandom_range(0, 255))), draw_gap());
      end
    end
  endtask

  initial begin
    logic [7:0] codes [12];
    int unsigned reads_after [6];
    codes = '{8'h41, 8'h00, 8'hFF, 8'h80, 8'h0D, 8'h7F, 8'h55, 8'hAA,
              tcw_pkg::NEWLINE_CODE, 8'h20, tcw_pkg::NEWLINE_CODE, 8'h01};
    reads_after = '{0, 1, 2, 7, 80, 160};

    repeat (4) @(negedge clk);
    rst = 1'b0;

    write_enable(1'b1);
    send(read_of(0), draw_gap());
    send(read_of(tcw_pkg::CELL_COUNT - 1), draw_gap());
    send(read_of(tcw_pkg::CELL_COUNT), draw_gap());
    send(read_of(2047), draw_gap());
    foreach (codes[i]) send(put_of(codes[i]), draw_gap());
    foreach (reads_after[i]) send(read_of(reads_after[i]), draw_gap());

    quiesce();
    write_enable(1'b0);
    run_random(30, 10, 30);
    quiesce();
    write_enable(1'b1);
    run_random(110, 15, 30);
    quiesce();
    run_random(110, 15, 30);
    quiesce();
    write_enable(1'b0);
    run_random(15, 10, 30);
    quiesce();
    write_enable(1'b1);
    // Long lines so the cursor wraps at the right edge as well as on newlines.
    run_random(160, 2, 20);

    quiesce();
    repeat (2010) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ text_console_writer_unit.f @@
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_unit.sv
tb/text_console_writer_unit_test.sv
